// ===== rtl/abes_pkg.sv =====
// abes_pkg: shared types, codes and constants for the advertising event sequencer
// no dependencies; imported by every module of the block
package abes_pkg;

  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 48;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int RND_W           = 8;
  localparam int DIST_W          = 24;
  localparam int PROD_W          = 25;

  localparam logic [5:0]  CH_BEFORE_FIRST = 6'd36;
  localparam logic [5:0]  CH_FIRST        = 6'd37;
  localparam logic [5:0]  CH_LAST         = 6'd39;
  localparam logic [3:0]  PDU_SCAN_REQ    = 4'h3;
  localparam logic [7:0]  SCAN_REQ_LEN    = 8'h0C;
  localparam logic [PROD_W-1:0] SLOT_US   = 25'd625;
  localparam logic [PROD_W-1:0] JIT_US    = 25'd1000;

  localparam logic [2:0]  MAP_RESET  = 3'd7;
  localparam logic [14:0] IVAL_RESET = 15'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAN_MAP    = 3'd0,
    CFG_IVAL_LO     = 3'd1,
    CFG_IVAL_HI     = 3'd2,
    CFG_OWN_ADDRESS = 3'd3,
    CFG_RUN_ENABLE  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_START     = 2'd0,
    REQ_RADIO_OFF = 2'd1,
    REQ_TIMEOUT   = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_TX_ADV   = 3'd1,
    ACT_LISTEN   = 3'd2,
    ACT_SCAN_RSP = 3'd3,
    ACT_DISABLE  = 3'd4,
    ACT_NEXT     = 3'd5,
    ACT_END      = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ADV    = 2'd1,
    PH_LISTEN = 2'd2,
    PH_WAIT   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_FIN  = 2'd2
  } bk_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        crc_ok;
    logic [7:0]  pdu_header;
    logic [7:0]  pdu_length;
    logic [47:0] scanner_address;
    logic [47:0] target_address;
    logic [7:0]  random_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  channel_number;
    logic [23:0] next_distance_us;
    logic        report_valid;
    logic [47:0] report_address;
    logic        report_addr_random;
    logic [15:0] valid_count;
    logic [15:0] invalid_count;
  } out_item_t;

  // classified transaction handed from front to back through the queue
  typedef struct packed {
    logic [1:0]       req;
    logic             crc_ok;
    logic             match;
    logic             addr_random;
    logic [47:0]      scanner;
    logic [RND_W-1:0] rnd;
  } cls_item_t;

  typedef struct packed {
    logic [2:0]  chan_map;
    logic [14:0] ival_lo;
    logic [14:0] ival_hi;
    logic        run_enable;
  } seq_cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   busy;
  } bk_status_t;

endpackage

// ===== rtl/abes_front.sv =====
// abes_front: input handshake and scan request classification
// depends on abes_pkg; feeds abes_queue
module abes_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  abes_pkg::in_item_t in_data,
  input  logic [47:0]       own_address,
  input  logic              q_full,
  output logic              q_push,
  output abes_pkg::cls_item_t q_item
);
  import abes_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.req         = in_data.req_type;
    q_item.crc_ok      = in_data.crc_ok;
    q_item.match       = in_data.crc_ok &&
                         (in_data.pdu_header[3:0] == PDU_SCAN_REQ) &&
                         (in_data.pdu_length == SCAN_REQ_LEN) &&
                         (in_data.target_address == own_address);
    q_item.addr_random = in_data.pdu_header[6];
    q_item.scanner     = in_data.scanner_address;
    q_item.rnd         = in_data.random_value;
  end

endmodule

// ===== rtl/abes_queue.sv =====
// abes_queue: small register queue between front and back
// depends on abes_pkg for the entry type
module abes_queue #(
  parameter int DEPTH = abes_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  abes_pkg::cls_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output abes_pkg::cls_item_t head
);
  import abes_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cls_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/abes_back.sv =====
// abes_back: event state machine, counters, bit-serial jitter remainder, output register
// depends on abes_pkg; takes classified transactions from abes_queue
module abes_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  abes_pkg::seq_cfg_t   cfg,
  input  logic                 q_valid,
  input  abes_pkg::cls_item_t  q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output abes_pkg::out_item_t  out_data,
  output abes_pkg::bk_status_t status
);
  import abes_pkg::*;

  localparam int CNT_W = $clog2(RND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RND_W - 1);

  bk_state_t   state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [5:0]  chan_r, chan_nxt;
  logic [15:0] good_r, good_nxt, bad_r, bad_nxt;
  out_item_t   out_r, out_nxt, res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [PROD_W-1:0] base_r, base_nxt, span_r, span_nxt;
  logic              jit_r, jit_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt, rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              out_free;
  logic [5:0]        ch_start, ch_wait;
  out_item_t         step_res;
  logic              fin;
  logic [RND_W:0]    div_try, div_res;
  logic [PROD_W-1:0] jitter, dist_sum;
  logic [DIST_W-1:0] dist_sat;

  // next enabled channel above cur, or one past the last channel
  function automatic logic [5:0] next_chan(input logic [5:0] cur, input logic [2:0] map);
    logic [5:0] c;
    logic [5:0] res;
    c   = (cur < CH_BEFORE_FIRST) ? CH_BEFORE_FIRST : cur;
    res = CH_LAST + 6'd1;
    for (int i = 2; i >= 0; i--) begin
      if (map[i] && ((CH_FIRST + 6'(i)) > c)) begin
        res = CH_FIRST + 6'(i);
      end
    end
    return res;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign ch_start  = next_chan(CH_BEFORE_FIRST, cfg.chan_map);
  assign ch_wait   = next_chan(chan_r, cfg.chan_map);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign status    = '{phase: phase_r, busy: (state_r != BK_IDLE)};

  // restoring remainder step, one random bit per cycle
  assign div_try = {rem_r, rnd_r[RND_W-1]};
  assign div_res = ({(PROD_W-RND_W-1)'(0), div_try} >= span_r) ?
                   div_try - span_r[RND_W:0] : div_try;

  assign jitter   = jit_r ? JIT_US * PROD_W'(rem_r) : '0;
  assign dist_sum = base_r + jitter;
  assign dist_sat = (dist_sum > PROD_W'({DIST_W{1'b1}})) ? '1 : dist_sum[DIST_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    chan_nxt      = chan_r;
    good_nxt      = good_r;
    bad_nxt       = bad_r;
    out_nxt       = out_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    base_nxt      = base_r;
    span_nxt      = span_r;
    jit_nxt       = jit_r;
    rnd_nxt       = rnd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    q_pop         = 1'b0;
    fin           = 1'b0;
    step_res      = '0;
    step_res.action = ACT_NONE;

    case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_item.req)
            REQ_START: begin
              chan_nxt = ch_start;
              if (ch_start > CH_LAST) begin
                fin = 1'b1;
              end else begin
                phase_nxt       = PH_ADV;
                step_res.action = ACT_TX_ADV;
              end
            end
            REQ_RADIO_OFF: begin
              case (phase_r)
                PH_ADV: begin
                  phase_nxt       = PH_LISTEN;
                  step_res.action = ACT_LISTEN;
                end
                PH_LISTEN: begin
                  phase_nxt = PH_WAIT;
                  if (!q_item.crc_ok) begin
                    bad_nxt = bad_r + 16'd1;
                  end
                  if (q_item.match) begin
                    good_nxt                    = good_r + 16'd1;
                    step_res.action             = ACT_SCAN_RSP;
                    step_res.report_valid       = 1'b1;
                    step_res.report_address     = q_item.scanner;
                    step_res.report_addr_random = q_item.addr_random;
                  end else begin
                    step_res.action = ACT_DISABLE;
                  end
                end
                PH_WAIT: begin
                  chan_nxt = ch_wait;
                  if (ch_wait > CH_LAST) begin
                    fin = 1'b1;
                  end else begin
                    phase_nxt       = PH_ADV;
                    step_res.action = ACT_TX_ADV;
                  end
                end
                default: ;
              endcase
            end
            REQ_TIMEOUT: begin
              if (phase_r == PH_LISTEN) begin
                phase_nxt       = PH_WAIT;
                step_res.action = ACT_DISABLE;
              end
            end
            default: ;
          endcase

          if (fin) begin
            phase_nxt       = PH_IDLE;
            step_res.action = cfg.run_enable ? ACT_NEXT : ACT_END;
          end
          if ((step_res.action == ACT_TX_ADV) || (step_res.action == ACT_LISTEN) ||
              (step_res.action == ACT_SCAN_RSP)) begin
            step_res.channel_number = chan_nxt;
          end
          step_res.valid_count   = good_nxt;
          step_res.invalid_count = bad_nxt;

          if (fin && cfg.run_enable) begin
            // hold the result back until the jitter remainder is done
            res_nxt   = step_res;
            base_nxt  = SLOT_US * PROD_W'(cfg.ival_lo);
            span_nxt  = SLOT_US * PROD_W'(cfg.ival_hi - cfg.ival_lo);
            jit_nxt   = (cfg.ival_hi > cfg.ival_lo);
            rnd_nxt   = q_item.rnd;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = BK_DIV;
          end else begin
            out_nxt       = step_res;
            out_valid_nxt = 1'b1;
          end
        end
      end
      BK_DIV: begin
        rem_nxt = div_res[RND_W-1:0];
        rnd_nxt = {rnd_r[RND_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        if (out_free) begin
          out_nxt                  = res_r;
          out_nxt.next_distance_us = dist_sat;
          out_valid_nxt            = 1'b1;
          state_nxt                = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      phase_r     <= PH_IDLE;
      chan_r      <= CH_BEFORE_FIRST;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      chan_r      <= chan_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    res_r  <= res_nxt;
    base_r <= base_nxt;
    span_r <= span_nxt;
    jit_r  <= jit_nxt;
    rnd_r  <= rnd_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// ===== rtl/ble_advertising_event_sequencer.sv =====
// ble_advertising_event_sequencer: top level, configuration registers and assertions
// depends on abes_pkg, abes_front, abes_queue and abes_back
//
// Steps a link layer advertiser through one advertising event over the enabled
// channels 37 to 39: each input transaction (timeslot start, radio disabled,
// receive timeout) yields exactly one result transaction carrying the radio
// action, the channel, the scan request report and the running valid and
// invalid request counts. Inputs are classified and queued in front of the
// event state machine, so the input side keeps accepting while a result waits
// until the queue is full, and then stalls.
// An input is classified combinationally in the front, registered in the queue
// and taken by the back into its output register; a transaction that ends the
// event with run_enable set first passes through the bit-serial remainder unit,
// which reduces the 8-bit random value modulo the interval span one bit per cycle.
// The distance to the next event saturates at 24 bits.
module ble_advertising_event_sequencer #(
  parameter int QUEUE_DEPTH = abes_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  abes_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output abes_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [abes_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [abes_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import abes_pkg::*;

  seq_cfg_t    cfg_r;
  logic [47:0] own_addr_r;

  logic       q_full, q_push, q_pop, q_valid;
  cls_item_t  cls_item, q_head;
  bk_status_t bk_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chan_map   <= MAP_RESET;
      cfg_r.ival_lo    <= IVAL_RESET;
      cfg_r.ival_hi    <= IVAL_RESET;
      cfg_r.run_enable <= 1'b0;
      own_addr_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHAN_MAP:    cfg_r.chan_map   <= cfg_data[2:0];
        CFG_IVAL_LO:     cfg_r.ival_lo    <= cfg_data[14:0];
        CFG_IVAL_HI:     cfg_r.ival_hi    <= cfg_data[14:0];
        CFG_OWN_ADDRESS: own_addr_r       <= cfg_data[47:0];
        CFG_RUN_ENABLE:  cfg_r.run_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  abes_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .own_address (own_addr_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (cls_item)
  );

  abes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (cls_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  abes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (bk_status)
  );

  // back takes a transaction only when the output register can take its result
  a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid || !out_stall))
    else $error("back popped while output register was blocked");

  // remainder unit runs with nothing else leaving the queue
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.busy |-> !q_pop)
    else $error("queue popped during jitter computation");

  // an event that has ended leaves the sequencer idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_data.action == ACT_NEXT) || (out_data.action == ACT_END)))
      |-> (bk_status.phase == PH_IDLE))
    else $error("event finished but phase not idle");

  // radio actions always name a real advertising channel
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_data.action == ACT_TX_ADV) || (out_data.action == ACT_LISTEN) ||
                   (out_data.action == ACT_SCAN_RSP)))
      |-> ((out_data.channel_number >= CH_FIRST) && (out_data.channel_number <= CH_LAST)))
    else $error("radio action on channel outside 37 to 39");

endmodule
